// File: rtl/lad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lad_pkg
// Shared types and constants for the linear array deque unit.
// ----------------------------------------------------------------------------
package lad_pkg;

    localparam int DEPTH_DEF      = 8;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FIELD_W        = 32;

    typedef enum logic [1:0] {
        CMD_PUSH_REAR  = 2'd0,
        CMD_PUSH_FRONT = 2'd1,
        CMD_POP_REAR   = 2'd2,
        CMD_POP_FRONT  = 2'd3
    } cmd_e_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_REAR_END  = 3'd2,
        ST_FRONT_END = 3'd3,
        ST_EMPTY     = 3'd4
    } status_e_t;

    typedef struct packed {
        cmd_e_t                    command;
        logic signed [FIELD_W-1:0] push_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]                status;
        logic signed [FIELD_W-1:0] pop_value;
    } out_item_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic commit;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_stall;
    } dp_stat_t;

endpackage

// File: rtl/lad_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lad_ctrl
// Sequencer: takes one transaction, then commits it once the result
// register is free.
// ----------------------------------------------------------------------------
module lad_ctrl
    import lad_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output ctl_cmd_t ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!stat.out_stall) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        ctl.load   = 1'b0;
        ctl.commit = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                ctl.load = s_valid;
            end
            S_EXEC: begin
                ctl.commit = !stat.out_stall;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/lad_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lad_datapath
// Slot memory, head and tail pointers, empty flag and result register.
// ----------------------------------------------------------------------------
module lad_datapath
    import lad_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  ctl_cmd_t  ctl,
    output dp_stat_t  stat,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [IDX_W-1:0] ZERO_IDX = '0;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [IDX_W-1:0]      head_reg, head_next;
    logic [IDX_W-1:0]      tail_reg, tail_next;
    logic                  empty_reg, empty_next;
    cmd_e_t                cmd_reg;
    logic [DATA_WIDTH-1:0] wval_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic                  m_valid_reg;
    out_item_t             m_data_reg;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [IDX_W-1:0]      rd_addr;
    logic [2:0]            status;
    logic                  popped;
    logic                  full;
    logic [63:0]           push_ext;
    logic [63:0]           rd_ext;

    assign push_ext = {32'b0, s_data.push_value};
    assign rd_ext   = 64'(rd_data_reg);
    assign rd_addr  = (s_data.command == CMD_POP_REAR) ? tail_reg : head_reg;
    assign full     = !empty_reg && (head_reg == ZERO_IDX) && (tail_reg == LAST_IDX);

    // operand capture and slot read at accept
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg     <= s_data.command;
            wval_reg    <= push_ext[DATA_WIDTH-1:0];
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wval_reg;
        end
    end

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        wr_en      = 1'b0;
        wr_addr    = ZERO_IDX;
        status     = ST_OK;
        popped     = 1'b0;
        if (cmd_reg == CMD_PUSH_REAR || cmd_reg == CMD_PUSH_FRONT) begin
            priority if (full) begin
                status = ST_FULL;
            end else if (empty_reg) begin
                head_next  = ZERO_IDX;
                tail_next  = ZERO_IDX;
                empty_next = 1'b0;
                wr_en      = 1'b1;
                wr_addr    = ZERO_IDX;
            end else if (cmd_reg == CMD_PUSH_REAR) begin
                if (tail_reg == LAST_IDX) begin
                    status = ST_REAR_END;
                end else begin
                    tail_next = tail_reg + 1'b1;
                    wr_en     = 1'b1;
                    wr_addr   = tail_reg + 1'b1;
                end
            end else begin
                if (head_reg == ZERO_IDX) begin
                    status = ST_FRONT_END;
                end else begin
                    head_next = head_reg - 1'b1;
                    wr_en     = 1'b1;
                    wr_addr   = head_reg - 1'b1;
                end
            end
        end else begin
            priority if (empty_reg) begin
                status = ST_EMPTY;
            end else if (head_reg == tail_reg) begin
                popped     = 1'b1;
                head_next  = ZERO_IDX;
                tail_next  = ZERO_IDX;
                empty_next = 1'b1;
            end else if (cmd_reg == CMD_POP_REAR) begin
                popped    = 1'b1;
                tail_next = tail_reg - 1'b1;
            end else begin
                popped    = 1'b1;
                head_next = head_reg + 1'b1;
            end
        end
        if (!ctl.commit) begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= ZERO_IDX;
            tail_reg    <= ZERO_IDX;
            empty_reg   <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            if (ctl.commit) begin
                head_reg    <= head_next;
                tail_reg    <= tail_next;
                empty_reg   <= empty_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.commit) begin
            m_data_reg.status    <= status;
            m_data_reg.pop_value <= popped ? $signed(rd_ext[31:0]) : '0;
        end
    end

    assign stat.out_stall = m_valid_reg && !m_ready;
    assign m_valid        = m_valid_reg;
    assign m_data         = m_data_reg;

endmodule

// File: rtl/linear_array_deque_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_array_deque_unit
// Non-circular double-ended queue over a fixed slot array: push or pop at
// either end, one status and popped value returned per command.
// ----------------------------------------------------------------------------
//
//  channel | ports                    | carries
//  --------+--------------------------+------------------------------------
//  s_      | s_valid s_ready s_data   | command, push_value
//  m_      | m_valid m_ready m_data   | status, pop_value
//
//  each transaction is an accept (slot read issued into the
//  registered memory output), then a commit (pointers, slot write, result)
//  s_ready is high only while no command is in flight
//  the result register lets a new transaction in while a result waits
//  a stalled result register holds the commit cycle until m_ready
//  synchronous active-low reset clears the sequencer state, result valid,
//  pointers and the empty flag; the slot memory is not cleared and needs
//  no clearing pass
//
module linear_array_deque_unit
    import lad_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    ctl_cmd_t ctl;
    dp_stat_t stat;

    // sequencer
    lad_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctl     (ctl)
    );

    // slot memory, pointers and result register
    lad_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .stat    (stat),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: rtl/lad_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lad_checker
// Port-level checks for the linear array deque unit.
// ----------------------------------------------------------------------------
module lad_checker
    import lad_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");

    // waiting command holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_data)))
        else $error("command changed while waiting");

    // one command in flight at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("accepted a second transaction while busy");

    // only defined status codes leave the block
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status <= ST_EMPTY))
        else $error("undefined status code");

    // failed commands return zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != ST_OK) |-> (m_data.pop_value == '0))
        else $error("nonzero pop value on failed command");

endmodule

bind linear_array_deque_unit lad_checker u_lad_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: tb/linear_array_deque_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_array_deque_unit_tb
// Self-checking bench for the linear array deque: a directed table for the
// edge cases, then random command streams checked against a behavioral deque,
// run under several patterns of sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------
module linear_array_deque_unit_tb;
    import lad_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int DW         = DATA_WIDTH_DEF;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CLK_HALF   = 6;
    localparam int RAND_ITEMS = 335;   // per idling phase, four phases

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    linear_array_deque_unit #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DW)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // ------------------------------------------------------------------------
    // behavioral deque: slot array, head and tail pointers, empty flag
    // ------------------------------------------------------------------------
    logic [DW-1:0]    mdl_slots [DEPTH];
    logic [IDX_W-1:0] mdl_head  = '0;
    logic [IDX_W-1:0] mdl_tail  = '0;
    logic             mdl_empty = 1'b1;

    out_item_t expected_results [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int sent_count     = 0;
    int checked_count  = 0;
    int status_seen [5];

    // computes the result of one command and advances the deque state
    function automatic out_item_t deque_predict(cmd_e_t cmd, logic [FIELD_W-1:0] value);
        out_item_t        res;
        logic [DW-1:0]    v;
        logic             full;
        logic [IDX_W-1:0] idx;
        res.status    = ST_OK;
        res.pop_value = '0;
        v    = value[DW-1:0];
        full = !mdl_empty && mdl_head == 0 && mdl_tail == IDX_W'(DEPTH - 1);
        case (cmd)
            CMD_PUSH_REAR, CMD_PUSH_FRONT: begin
                if (full) begin
                    res.status = ST_FULL;
                end else if (mdl_empty) begin
                    // first element always lands in slot 0
                    mdl_head     = '0;
                    mdl_tail     = '0;
                    mdl_slots[0] = v;
                    mdl_empty    = 1'b0;
                end else if (cmd == CMD_PUSH_REAR) begin
                    if (mdl_tail == IDX_W'(DEPTH - 1)) begin
                        res.status = ST_REAR_END;
                    end else begin
                        mdl_tail            = mdl_tail + 1'b1;
                        mdl_slots[mdl_tail] = v;
                    end
                end else begin
                    if (mdl_head == 0) begin
                        res.status = ST_FRONT_END;
                    end else begin
                        mdl_head            = mdl_head - 1'b1;
                        mdl_slots[mdl_head] = v;
                    end
                end
            end
            default: begin
                if (mdl_empty) begin
                    res.status = ST_EMPTY;
                end else begin
                    idx           = (cmd == CMD_POP_REAR) ? mdl_tail : mdl_head;
                    res.pop_value = FIELD_W'(mdl_slots[idx]);
                    if (mdl_head == mdl_tail) begin
                        // last element gone, pointers go back to slot 0
                        mdl_head  = '0;
                        mdl_tail  = '0;
                        mdl_empty = 1'b1;
                    end else if (cmd == CMD_POP_REAR) begin
                        mdl_tail = mdl_tail - 1'b1;
                    end else begin
                        mdl_head = mdl_head + 1'b1;
                    end
                end
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // command driver: optional idle gap, then hold valid until the transaction
    // is taken; valid is only lowered when a gap follows
    // ------------------------------------------------------------------------
    task automatic send_command(cmd_e_t cmd, logic [FIELD_W-1:0] value, out_item_t res);
        in_item_t item;
        item.command    = cmd;
        item.push_value = value;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        expected_results.push_back(res);
        sent_count++;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // result monitor and back-pressure; values are sampled at the edge, and
    // m_ready is re-drawn with one nonblocking assignment per edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        out_item_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with no command outstanding, actual status %0d value %h",
                         $time, m_data.status, m_data.pop_value);
                error_count++;
            end else begin
                exp_res = expected_results.pop_front();
                checked_count++;
                if (m_data.status < 5) status_seen[m_data.status]++;
                if (m_data.status !== exp_res.status) begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, exp_res.status, m_data.status);
                    error_count++;
                end
                if (m_data.pop_value !== exp_res.pop_value) begin
                    $display("%0t: pop_value mismatch, expected %h actual %h",
                             $time, exp_res.pop_value, m_data.pop_value);
                    error_count++;
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // directed table: typed expectations only where they are obvious
    // ------------------------------------------------------------------------
    typedef struct {
        cmd_e_t              cmd;
        logic [FIELD_W-1:0]  value;
        bit                  typed;
        status_e_t           status;
        logic [FIELD_W-1:0]  pop_value;
    } dir_row_t;

    dir_row_t directed_rows [20] = '{
        '{CMD_POP_REAR,   32'h0000_0000, 1'b1, ST_EMPTY,     32'h0000_0000},
        '{CMD_POP_FRONT,  32'hffff_ffff, 1'b1, ST_EMPTY,     32'h0000_0000},
        '{CMD_PUSH_REAR,  32'h7fff_ffff, 1'b1, ST_OK,        32'h0000_0000},
        '{CMD_POP_FRONT,  32'h0000_0000, 1'b1, ST_OK,        32'h7fff_ffff},
        '{CMD_PUSH_FRONT, 32'h8000_0000, 1'b1, ST_OK,        32'h0000_0000},
        '{CMD_PUSH_FRONT, 32'h0000_0001, 1'b1, ST_FRONT_END, 32'h0000_0000},
        '{CMD_PUSH_REAR,  32'hffff_ffff, 1'b0, ST_OK,        32'h0000_0000},
        '{CMD_PUSH_REAR,  32'h0000_0000, 1'b0, ST_OK,        32'h0000_0000},
        '{CMD_PUSH_REAR,  32'h5555_5555, 1'b0, ST_OK,        32'h0000_0000},
        '{CMD_PUSH_REAR,  32'haaaa_aaaa, 1'b0, ST_OK,        32'h0000_0000},
        '{CMD_PUSH_REAR,  32'h1234_5678, 1'b0, ST_OK,        32'h0000_0000},
        '{CMD_PUSH_REAR,  32'h7fff_ffff, 1'b0, ST_OK,        32'h0000_0000},
        '{CMD_PUSH_REAR,  32'h8000_0001, 1'b0, ST_OK,        32'h0000_0000},
        '{CMD_PUSH_REAR,  32'h0000_0005, 1'b1, ST_FULL,      32'h0000_0000},
        '{CMD_PUSH_FRONT, 32'h0000_0005, 1'b1, ST_FULL,      32'h0000_0000},
        '{CMD_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK,        32'h0000_0000},
        '{CMD_PUSH_REAR,  32'h0000_0002, 1'b1, ST_REAR_END,  32'h0000_0000},
        '{CMD_PUSH_FRONT, 32'haaaa_aaaa, 1'b0, ST_OK,        32'h0000_0000},
        '{CMD_POP_REAR,   32'h5555_5555, 1'b0, ST_OK,        32'h0000_0000},
        '{CMD_POP_REAR,   32'h0000_0000, 1'b0, ST_OK,        32'h0000_0000}
    };

    // random command: push share set by the current bias, so the deque
    // swings between full and empty and hits both ends
    task automatic send_random(int push_pct);
        cmd_e_t             cmd;
        logic [FIELD_W-1:0] value;
        bit                 is_push;
        bit                 front;
        is_push = ($urandom_range(0, 99) < push_pct);
        front   = 1'($urandom_range(0, 1));
        if (is_push) cmd = front ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
        else         cmd = front ? CMD_POP_FRONT  : CMD_POP_REAR;
        case ($urandom_range(0, 11))
            0:       value = 32'h0000_0000;
            1:       value = 32'hffff_ffff;
            2:       value = 32'h7fff_ffff;
            3:       value = 32'h8000_0000;
            default: value = $urandom;
        endcase
        send_command(cmd, value, deque_predict(cmd, value));
    endtask

    initial begin
        out_item_t res;
        int        push_pct;
        foreach (status_seen[k]) status_seen[k] = 0;

        // synchronous reset, held low and then released
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part with no idling on either side
        foreach (directed_rows[r]) begin
            res = deque_predict(directed_rows[r].cmd, directed_rows[r].value);
            if (directed_rows[r].typed) begin
                res.status    = directed_rows[r].status;
                res.pop_value = directed_rows[r].pop_value;
            end
            send_command(directed_rows[r].cmd, directed_rows[r].value, res);
        end

        // random part over four idling phases
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            push_pct = 50;
            for (int n = 0; n < RAND_ITEMS; n++) begin
                // re-draw the bias every 24 transactions: push heavy, pop heavy or even
                if (n % 24 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       push_pct = 75;
                        1:       push_pct = 25;
                        default: push_pct = 50;
                    endcase
                end
                send_random(push_pct);
            end
        end
        s_valid <= 1'b0;

        // drain: let back-pressure go so leftover results come out
        recv_stall_pct = 0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("covered %0d commands (%0d from the table), %0d results compared",
                 sent_count, $size(directed_rows), checked_count);
        $display("status mix: ok %0d, full %0d, rear end %0d, front end %0d, empty %0d",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_REAR_END],
                 status_seen[ST_FRONT_END], status_seen[ST_EMPTY]);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("Verification failed");
        $finish;
    end

endmodule

// File: linear_array_deque_unit.f
rtl/lad_pkg.sv
rtl/lad_ctrl.sv
rtl/lad_datapath.sv
rtl/linear_array_deque_unit.sv
rtl/lad_checker.sv
tb/linear_array_deque_unit_tb.sv
